FILE: design/psdd_pkg.sv
package psdd_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_POLY,
        ST_RD,
        ST_CMP,
        ST_ERD,
        ST_ECMP,
        ST_DONE
    } top_state_t;

    typedef enum logic [2:0] {
        P_IDLE,
        P_EDGE,
        P_DIV,
        P_CMP,
        P_FIN
    } poly_state_t;

    typedef struct packed {
        logic done;
        logic in_poly;
    } poly_res_t;

    typedef logic [2:0][63:0] vregs_t;

    localparam logic [1:0] KIND_DONE   = 2'd0;
    localparam logic [1:0] KIND_STOP   = 2'd1;
    localparam logic [1:0] KIND_UNSTOP = 2'd2;

    localparam logic [2:0] REG_VCOUNT  = 3'd0;
    localparam logic [2:0] REG_VERT_A  = 3'd1;
    localparam logic [2:0] REG_VERT_B  = 3'd2;
    localparam logic [2:0] REG_VERT_C  = 3'd3;
    localparam logic [2:0] REG_HIST    = 3'd4;
    localparam logic [2:0] REG_MOVE    = 3'd5;
    localparam logic [2:0] REG_THRESH  = 3'd6;
    localparam logic [2:0] REG_RECORD  = 3'd7;

    function automatic logic [15:0] vert_coord(input vregs_t v, input logic [2:0] k,
                                               input logic y_part);
        logic [63:0] r;
        logic [5:0]  sh;
        r  = v[k[2:1]];
        sh = {k[0], y_part, 4'd0};
        return 16'(r >> sh);
    endfunction

endpackage

FILE: design/psdd_ram.sv
module psdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/psdd_poly.sv
module psdd_poly import psdd_pkg::*; #(
    parameter int MAX_VERTICES = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [11:0] px,
    input  logic [11:0] py,
    input  logic [2:0]  vcount,
    input  vregs_t      verts,
    output poly_res_t   res
);

    poly_state_t state_reg, state_next;
    logic [2:0]  i_reg, i_next, j_reg, j_next, nv;
    logic        in_reg, in_next, neg_reg, neg_next;
    logic [31:0] rem_reg, rem_next, dsh_reg, dsh_next;
    logic [15:0] q_reg, q_next, xi_reg, xi_next;
    logic [3:0]  cnt_reg, cnt_next;

    logic [15:0] xi, yi, xj, yj, py16, dx_mag, dy_mag, dd_mag;
    logic [16:0] dxs, dys, dds, dxn, dyn, ddn;
    logic [17:0] qs, crs;
    logic        ge;

    assign nv = (32'(vcount) > MAX_VERTICES) ? 3'(MAX_VERTICES) : vcount;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        in_reg  <= in_next;
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        xi_reg  <= xi_next;
        cnt_reg <= cnt_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        in_next     = in_reg;
        neg_next    = neg_reg;
        rem_next    = rem_reg;
        dsh_next    = dsh_reg;
        q_next      = q_reg;
        xi_next     = xi_reg;
        cnt_next    = cnt_reg;
        res.done    = 1'b0;
        res.in_poly = in_reg;

        py16 = {4'd0, py};
        xi   = vert_coord(verts, i_reg, 1'b0);
        yi   = vert_coord(verts, i_reg, 1'b1);
        xj   = vert_coord(verts, j_reg, 1'b0);
        yj   = vert_coord(verts, j_reg, 1'b1);
        dxs  = {1'b0, xj} - {1'b0, xi};
        dys  = {1'b0, py16} - {1'b0, yi};
        dds  = {1'b0, yj} - {1'b0, yi};
        dxn  = -dxs;
        dyn  = -dys;
        ddn  = -dds;
        dx_mag = dxs[16] ? dxn[15:0] : dxs[15:0];
        dy_mag = dys[16] ? dyn[15:0] : dys[15:0];
        dd_mag = dds[16] ? ddn[15:0] : dds[15:0];
        ge   = (rem_reg >= dsh_reg);
        qs   = neg_reg ? -{2'd0, q_reg} : {2'd0, q_reg};
        crs  = {2'd0, xi_reg} + qs;

        case (state_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    i_next  = 3'd0;
                    j_next  = nv - 3'd1;
                    in_next = 1'b0;
                    state_next = (nv == 3'd0) ? P_FIN : P_EDGE;
                end
            end
            P_EDGE:
            begin
                if ((yi > py16) != (yj > py16))
                begin
                    rem_next   = dx_mag * dy_mag;
                    dsh_next   = {1'b0, dd_mag, 15'd0};
                    neg_next   = dxs[16] ^ dys[16] ^ dds[16];
                    xi_next    = xi;
                    q_next     = 16'd0;
                    cnt_next   = 4'd15;
                    state_next = P_DIV;
                end
                else if (i_reg == nv - 3'd1)
                begin
                    state_next = P_FIN;
                end
                else
                begin
                    j_next = i_reg;
                    i_next = i_reg + 3'd1;
                end
            end
            P_DIV:
            begin
                if (ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                q_next   = {q_reg[14:0], ge};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    state_next = P_CMP;
                end
            end
            P_CMP:
            begin
                if ($signed({6'd0, px}) < $signed(crs))
                begin
                    in_next = !in_reg;
                end
                if (i_reg == nv - 3'd1)
                begin
                    state_next = P_FIN;
                end
                else
                begin
                    j_next     = i_reg;
                    i_next     = i_reg + 3'd1;
                    state_next = P_EDGE;
                end
            end
            P_FIN:
            begin
                res.done   = 1'b1;
                state_next = P_IDLE;
            end
            default:
            begin
                state_next = P_IDLE;
            end
        endcase
    end

endmodule

FILE: design/polygon_stop_dwell_detector.sv
// Stopped-object dwell detector. Target transfers (cmd 0) are qualified by track length,
// an even-odd polygon test and a squared-movement limit; a qualifying target bumps a
// saturating counter in a track table held in one RAM of MAX_TRACKS entries. An
// end-of-frame transfer (cmd 1) scans the table and emits stop/unstop events in slot
// order, closed by a frame-done result with last set. A target that passes the track
// checks runs the polygon test edge by edge, with one 16-step shift-subtract divider for
// each edge that straddles the point, then reads and compares the table slot by slot. An
// end-of-frame item reads and compares every slot in turn, waiting while the output is
// stalled. Configuration sits on a 64-bit APB port, register i at byte address 8*i;
// write it only while the block is idle.
module polygon_stop_dwell_detector import psdd_pkg::*; #(
    parameter int MAX_TRACKS   = 32,
    parameter int MAX_VERTICES = 6,
    parameter int COORD_BITS   = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [15:0] target_id,
    input  logic        is_tracked,
    input  logic [9:0]  track_len,
    input  logic [11:0] cur_x,
    input  logic [11:0] cur_y,
    input  logic [11:0] past_x,
    input  logic [11:0] past_y,
    input  logic [31:0] frame_number,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_kind,
    output logic [15:0] event_track,
    output logic [31:0] event_frame,
    output logic        want_image,
    output logic        want_video,
    output logic        table_overflow,
    output logic        last
);

    localparam int IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TRACKS - 1);
    localparam logic [11:0] CMASK = 12'((1 << COORD_BITS) - 1);

    logic [2:0]  vcount_reg;
    vregs_t      verts_reg;
    logic [9:0]  hist_reg;
    logic [11:0] move_reg;
    logic [15:0] thresh_reg;
    logic [1:0]  record_reg;

    top_state_t  state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [MAX_TRACKS-1:0] valid_reg, valid_next, hit_reg, hit_next;
    logic        ovf_reg, ovf_next;

    logic        cmd_reg, trk_reg;
    logic [15:0] tid_reg;
    logic [9:0]  len_reg;
    logic [11:0] cx_reg, cy_reg;
    logic [31:0] frame_reg;
    logic [25:0] dx2_reg, dy2_reg;
    logic [23:0] lim2_reg;

    logic        ov_reg, ov_next;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] etrk_reg, etrk_next;
    logic [31:0] efr_reg, efr_next;
    logic        img_reg, img_next, vid_reg, vid_next, tov_reg, tov_next, last_reg, last_next;

    logic        we, poly_start, accept, busy, emit, free_any;
    logic [IW-1:0] waddr, free_idx;
    logic [31:0] wdata, rdata;
    logic [15:0] rd_track, rd_count;
    logic [12:0] dx, dy;
    logic [25:0] dxe, dye;
    logic [11:0] cxm, cym, pxm, pym;
    poly_res_t   pres;

    assign pready = 1'b1;
    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign busy = ov_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= 3'd0;
            verts_reg  <= '0;
            hist_reg   <= 10'd20;
            move_reg   <= 12'd8;
            thresh_reg <= 16'd50;
            record_reg <= 2'd0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[5:3])
                REG_VCOUNT: vcount_reg   <= pwdata[2:0];
                REG_VERT_A: verts_reg[0] <= pwdata;
                REG_VERT_B: verts_reg[1] <= pwdata;
                REG_VERT_C: verts_reg[2] <= pwdata;
                REG_HIST:   hist_reg     <= pwdata[9:0];
                REG_MOVE:   move_reg     <= pwdata[11:0];
                REG_THRESH: thresh_reg   <= pwdata[15:0];
                REG_RECORD: record_reg   <= pwdata[1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            REG_VCOUNT: prdata = {61'd0, vcount_reg};
            REG_VERT_A: prdata = verts_reg[0];
            REG_VERT_B: prdata = verts_reg[1];
            REG_VERT_C: prdata = verts_reg[2];
            REG_HIST:   prdata = {54'd0, hist_reg};
            REG_MOVE:   prdata = {52'd0, move_reg};
            REG_THRESH: prdata = {48'd0, thresh_reg};
            REG_RECORD: prdata = {62'd0, record_reg};
            default:    prdata = 64'd0;
        endcase
    end

    assign cxm = cur_x & CMASK;
    assign cym = cur_y & CMASK;
    assign pxm = past_x & CMASK;
    assign pym = past_y & CMASK;
    assign dx  = {1'b0, cxm} - {1'b0, pxm};
    assign dy  = {1'b0, cym} - {1'b0, pym};
    assign dxe = {{13{dx[12]}}, dx};
    assign dye = {{13{dy[12]}}, dy};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            trk_reg   <= is_tracked;
            tid_reg   <= target_id;
            len_reg   <= track_len;
            cx_reg    <= cxm;
            cy_reg    <= cym;
            frame_reg <= frame_number;
            dx2_reg   <= dxe * dxe;
            dy2_reg   <= dye * dye;
            lim2_reg  <= {12'd0, move_reg} * {12'd0, move_reg};
        end
    end

    psdd_ram #(.WIDTH(32), .DEPTH(MAX_TRACKS)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    psdd_poly #(.MAX_VERTICES(MAX_VERTICES)) u_poly (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (poly_start),
        .px     (cx_reg),
        .py     (cy_reg),
        .vcount (vcount_reg),
        .verts  (verts_reg),
        .res    (pres)
    );

    assign rd_track = rdata[31:16];
    assign rd_count = rdata[15:0];

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int s = MAX_TRACKS - 1; s >= 0; s--)
        begin
            if (!valid_reg[s])
            begin
                free_any = 1'b1;
                free_idx = IW'(s);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            hit_reg   <= '0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        kind_reg <= kind_next;
        etrk_reg <= etrk_next;
        efr_reg  <= efr_next;
        img_reg  <= img_next;
        vid_reg  <= vid_next;
        tov_reg  <= tov_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        hit_next   = hit_reg;
        ovf_next   = ovf_reg;
        ov_next    = ov_reg && out_stall;
        kind_next  = kind_reg;
        etrk_next  = etrk_reg;
        efr_next   = efr_reg;
        img_next   = img_reg;
        vid_next   = vid_reg;
        tov_next   = tov_reg;
        last_next  = last_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = {tid_reg, (rd_count == 16'hFFFF) ? rd_count : rd_count + 16'd1};
        poly_start = 1'b0;
        emit       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                idx_next = '0;
                if (cmd_reg)
                begin
                    state_next = ST_ERD;
                end
                else if (trk_reg && len_reg >= hist_reg)
                begin
                    poly_start = 1'b1;
                    state_next = ST_POLY;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POLY:
            begin
                if (pres.done)
                begin
                    if (pres.in_poly && (27'(dx2_reg) + 27'(dy2_reg) <= 27'(lim2_reg)))
                    begin
                        state_next = ST_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (valid_reg[idx_reg] && rd_track == tid_reg)
                begin
                    we = 1'b1;
                    hit_next[idx_reg] = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    if (free_any)
                    begin
                        we    = 1'b1;
                        waddr = free_idx;
                        wdata = {tid_reg, 16'd1};
                        valid_next[free_idx] = 1'b1;
                        hit_next[free_idx]   = 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_ERD:
            begin
                state_next = ST_ECMP;
            end
            ST_ECMP:
            begin
                emit = valid_reg[idx_reg] &&
                       ((!hit_reg[idx_reg] && rd_count >= thresh_reg) ||
                        (hit_reg[idx_reg] && rd_count == thresh_reg));
                if (!(emit && busy))
                begin
                    if (emit)
                    begin
                        ov_next   = 1'b1;
                        kind_next = hit_reg[idx_reg] ? KIND_STOP : KIND_UNSTOP;
                        etrk_next = rd_track;
                        efr_next  = frame_reg;
                        img_next  = record_reg[0];
                        vid_next  = record_reg[1];
                        tov_next  = 1'b0;
                        last_next = 1'b0;
                    end
                    if (!hit_reg[idx_reg])
                    begin
                        valid_next[idx_reg] = 1'b0;
                    end
                    hit_next[idx_reg] = 1'b0;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_ERD;
                    end
                end
            end
            ST_DONE:
            begin
                if (!busy)
                begin
                    ov_next    = 1'b1;
                    kind_next  = KIND_DONE;
                    etrk_next  = 16'd0;
                    efr_next   = frame_reg;
                    img_next   = 1'b0;
                    vid_next   = 1'b0;
                    tov_next   = ovf_reg;
                    last_next  = 1'b1;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid      = ov_reg;
    assign event_kind     = kind_reg;
    assign event_track    = etrk_reg;
    assign event_frame    = efr_reg;
    assign want_image     = img_reg;
    assign want_video     = vid_reg;
    assign table_overflow = tov_reg;
    assign last           = last_reg;

endmodule

FILE: verif/testbench.sv
module testbench import psdd_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit        cmd;
        bit [15:0] tid;
        bit        trk;
        bit [9:0]  tlen;
        bit [11:0] cx;
        bit [11:0] cy;
        bit [11:0] px;
        bit [11:0] py;
        bit [31:0] frm;
    } target_t;

    typedef struct {
        bit [1:0]  kind;
        bit [15:0] tid;
        bit [31:0] frm;
        bit        img;
        bit        vid;
        bit        ovf;
        bit        fin;
    } dwell_event_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [15:0] target_id;
    logic        is_tracked;
    logic [9:0]  track_len;
    logic [11:0] cur_x;
    logic [11:0] cur_y;
    logic [11:0] past_x;
    logic [11:0] past_y;
    logic [31:0] frame_number;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  event_kind;
    logic [15:0] event_track;
    logic [31:0] event_frame;
    logic        want_image;
    logic        want_video;
    logic        table_overflow;
    logic        last;

    target_t      targets_to_send[$];
    target_t      cur_target;
    dwell_event_t events_due[$];

    // predictor copy of configuration and track table
    bit [2:0]  cfg_vcount;
    bit [63:0] cfg_verts[3];
    bit [9:0]  cfg_hist;
    bit [11:0] cfg_move;
    bit [15:0] cfg_thresh;
    bit [1:0]  cfg_record;
    bit        tab_valid[32];
    bit [15:0] tab_track[32];
    bit [15:0] tab_count[32];
    bit        tab_hit[32];
    bit        tab_overflow;

    bit quiet;
    bit send_hold;
    bit hold_req;
    int stall_left;
    int errors;
    int n_items;
    int n_stops;
    int n_unstops;
    int n_frames;
    int n_overflows;
    int idle_cycles;
    int region_lo;
    int region_hi;
    bit [15:0] id_pool[$];

    polygon_stop_dwell_detector u_top (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .target_id(target_id),
        .is_tracked(is_tracked), .track_len(track_len), .cur_x(cur_x), .cur_y(cur_y),
        .past_x(past_x), .past_y(past_y), .frame_number(frame_number),
        .out_valid(out_valid), .out_stall(out_stall), .event_kind(event_kind),
        .event_track(event_track), .event_frame(event_frame), .want_image(want_image),
        .want_video(want_video), .table_overflow(table_overflow), .last(last)
    );

    assign cmd          = cur_target.cmd;
    assign target_id    = cur_target.tid;
    assign is_tracked   = cur_target.trk;
    assign track_len    = cur_target.tlen;
    assign cur_x        = cur_target.cx;
    assign cur_y        = cur_target.cy;
    assign past_x       = cur_target.px;
    assign past_y       = cur_target.py;
    assign frame_number = cur_target.frm;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic longint vertex_coord(int k, int y_part);
        bit [63:0] r;
        r = cfg_verts[k / 2];
        return longint'(16'(r >> ((k % 2) * 32 + y_part * 16)));
    endfunction

    function automatic bit point_in_polygon(longint px, longint py);
        int     n;
        int     j;
        bit     c;
        longint xi, yi, xj, yj, cr;
        n = (cfg_vcount > 6) ? 6 : int'(cfg_vcount);
        c = 1'b0;
        if (n == 0)
            return 1'b0;
        j = n - 1;
        for (int i = 0; i < n; i++)
        begin
            xi = vertex_coord(i, 0);
            yi = vertex_coord(i, 1);
            xj = vertex_coord(j, 0);
            yj = vertex_coord(j, 1);
            if ((yi > py) != (yj > py))
            begin
                cr = (xj - xi) * (py - yi) / (yj - yi) + xi;
                if (px < cr)
                    c = ~c;
            end
            j = i;
        end
        return c;
    endfunction

    function automatic void push_event(bit [1:0] kind, bit [15:0] tid, bit [31:0] frm,
                                       bit ovf, bit fin);
        dwell_event_t e;
        e.kind = kind;
        e.tid  = tid;
        e.frm  = frm;
        e.img  = fin ? 1'b0 : cfg_record[0];
        e.vid  = fin ? 1'b0 : cfg_record[1];
        e.ovf  = ovf;
        e.fin  = fin;
        events_due = {events_due, e};
    endfunction

    function automatic void update_dwell(target_t t);
        longint dx, dy, lim;
        int     slot, free_slot;
        if (t.cmd == 1'b0)
        begin
            dx = longint'(t.cx) - longint'(t.px);
            dy = longint'(t.cy) - longint'(t.py);
            lim = longint'(cfg_move);
            if (!t.trk || t.tlen < cfg_hist)
                return;
            if (!point_in_polygon(longint'(t.cx), longint'(t.cy)))
                return;
            if (dx * dx + dy * dy > lim * lim)
                return;
            slot = -1;
            free_slot = -1;
            for (int s = 0; s < 32; s++)
            begin
                if (tab_valid[s])
                begin
                    if (slot < 0 && tab_track[s] == t.tid)
                        slot = s;
                end
                else if (free_slot < 0)
                    free_slot = s;
            end
            if (slot >= 0)
            begin
                if (tab_count[slot] != 16'hffff)
                    tab_count[slot]++;
                tab_hit[slot] = 1'b1;
            end
            else if (free_slot >= 0)
            begin
                tab_valid[free_slot] = 1'b1;
                tab_track[free_slot] = t.tid;
                tab_count[free_slot] = 16'd1;
                tab_hit[free_slot]   = 1'b1;
            end
            else
                tab_overflow = 1'b1;
        end
        else
        begin
            for (int s = 0; s < 32; s++)
            begin
                if (tab_valid[s])
                begin
                    if (!tab_hit[s])
                    begin
                        if (tab_count[s] >= cfg_thresh)
                            push_event(KIND_UNSTOP, tab_track[s], t.frm, 1'b0, 1'b0);
                        tab_valid[s] = 1'b0;
                    end
                    else if (tab_count[s] == cfg_thresh)
                        push_event(KIND_STOP, tab_track[s], t.frm, 1'b0, 1'b0);
                    tab_hit[s] = 1'b0;
                end
            end
            push_event(KIND_DONE, 16'd0, t.frm, tab_overflow, 1'b1);
            tab_overflow = 1'b0;
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            cur_target <= '{default: 0};
        end
        else
        begin
            if (in_valid && !in_stall)
                update_dwell(cur_target);
            if (!in_valid || !in_stall)
            begin
                if (targets_to_send.size() > 0 && !send_hold
                    && (quiet || $urandom_range(99) >= 20))
                begin
                    cur_target <= targets_to_send.pop_front();
                    in_valid   <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, longint expv, longint got);
        if (expv != got)
        begin
            $display("%0t: mismatch on %s: expected %0h, got %0h", $time, name, expv, got);
            errors++;
        end
    endfunction

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        dwell_event_t e;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (events_due.size() == 0)
                begin
                    $display("%0t: unexpected transfer, kind %0d track %0h",
                             $time, event_kind, event_track);
                    errors++;
                end
                else
                begin
                    e = events_due.pop_front();
                    check_field("event_kind", e.kind, event_kind);
                    check_field("event_track", e.tid, event_track);
                    check_field("event_frame", e.frm, event_frame);
                    check_field("want_image", e.img, want_image);
                    check_field("want_video", e.vid, want_video);
                    check_field("table_overflow", e.ovf, table_overflow);
                    check_field("last", e.fin, last);
                    if (event_kind == KIND_STOP)
                        n_stops++;
                    if (event_kind == KIND_UNSTOP)
                        n_unstops++;
                    if (last)
                        n_frames++;
                    if (table_overflow)
                        n_overflows++;
                end
            end
            if (hold_req)
            begin
                hold_req   <= 1'b0;
                stall_left <= 400;
                out_stall  <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < 20);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 20000)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic reg_write(bit [2:0] idx, bit [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_VCOUNT: cfg_vcount = val[2:0];
            REG_VERT_A: cfg_verts[0] = val;
            REG_VERT_B: cfg_verts[1] = val;
            REG_VERT_C: cfg_verts[2] = val;
            REG_HIST:   cfg_hist = val[9:0];
            REG_MOVE:   cfg_move = val[11:0];
            REG_THRESH: cfg_thresh = val[15:0];
            REG_RECORD: cfg_record = val[1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (targets_to_send.size() > 0 || in_valid || events_due.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic bit [63:0] vertex_pair(bit [15:0] x0, bit [15:0] y0,
                                              bit [15:0] x1, bit [15:0] y1);
        return {y1, x1, y0, x0};
    endfunction

    function automatic void queue_target(bit [15:0] tid, bit trk, bit [9:0] tlen,
                                         bit [11:0] cx, bit [11:0] cy,
                                         bit [11:0] px, bit [11:0] py);
        target_t t;
        t = '{cmd: 1'b0, tid: tid, trk: trk, tlen: tlen, cx: cx, cy: cy,
              px: px, py: py, frm: $urandom()};
        targets_to_send = {targets_to_send, t};
        n_items++;
    endfunction

    function automatic void queue_frame_end(bit [31:0] frm);
        target_t t;
        t = '{cmd: 1'b1, tid: 16'($urandom()), trk: 1'($urandom()),
              tlen: 10'($urandom()), cx: 12'($urandom()), cy: 12'($urandom()),
              px: 12'($urandom()), py: 12'($urandom()), frm: frm};
        targets_to_send = {targets_to_send, t};
        n_items++;
    endfunction

    function automatic bit [11:0] nudge(bit [11:0] c);
        int d, v;
        d = int'(cfg_move) + (($urandom_range(3) == 0) ? 2 : 0);
        v = int'(c) + int'($urandom_range(2 * d)) - d;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    function automatic void queue_random_frame();
        int        k;
        bit [11:0] cx, cy;
        k = $urandom_range(1, 8);
        for (int i = 0; i < k; i++)
        begin
            if ($urandom_range(99) < 85)
            begin
                cx = 12'($urandom_range(region_lo, region_hi));
                cy = 12'($urandom_range(region_lo, region_hi));
                queue_target(id_pool[$urandom_range(id_pool.size() - 1)], 1'b1,
                             10'($urandom_range(int'(cfg_hist), 1023)), cx, cy,
                             nudge(cx), nudge(cy));
            end
            else
                queue_target(16'($urandom()), 1'($urandom()), 10'($urandom()),
                             12'($urandom()), 12'($urandom()),
                             12'($urandom()), 12'($urandom()));
        end
        queue_frame_end($urandom());
    endfunction

    task automatic run_phase(int n_pool, int budget);
        int stop_at;
        id_pool.delete();
        for (int i = 0; i < n_pool; i++)
            id_pool = {id_pool, 16'($urandom())};
        stop_at = n_items + budget;
        while (n_items < stop_at)
            queue_random_frame();
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet = 1'b0;
        send_hold = 1'b0;
        hold_req = 1'b0;
        errors = 0;
        n_items = 0;
        n_stops = 0;
        n_unstops = 0;
        n_frames = 0;
        n_overflows = 0;
        idle_cycles = 0;
        cfg_vcount = 0;
        cfg_verts = '{default: 0};
        cfg_hist = 10'd20;
        cfg_move = 12'd8;
        cfg_thresh = 16'd50;
        cfg_record = 2'd0;
        tab_valid = '{default: 0};
        tab_track = '{default: 0};
        tab_count = '{default: 0};
        tab_hit = '{default: 0};
        tab_overflow = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: large pentagon, strict movement, threshold one
        reg_write(REG_VCOUNT, 64'd5);
        reg_write(REG_VERT_A, vertex_pair(16'd0, 16'd0, 16'hffff, 16'd0));
        reg_write(REG_VERT_B, vertex_pair(16'hffff, 16'hffff, 16'd0, 16'hffff));
        reg_write(REG_VERT_C, vertex_pair(16'd0, 16'h8000, 16'd0, 16'd0));
        reg_write(REG_HIST, 64'd1);
        reg_write(REG_MOVE, 64'd0);
        reg_write(REG_THRESH, 64'd1);
        reg_write(REG_RECORD, 64'd3);
        queue_target(16'hffff, 1'b1, 10'd1023, 12'd2000, 12'd2000, 12'd2000, 12'd2000);
        queue_target(16'hffff, 1'b1, 10'd1, 12'd2000, 12'd2000, 12'd2000, 12'd2000);
        queue_target(16'h0000, 1'b1, 10'd1023, 12'd0, 12'd0, 12'd0, 12'd0);
        queue_target(16'h1234, 1'b0, 10'd1023, 12'd100, 12'd100, 12'd100, 12'd100);
        queue_target(16'h2345, 1'b1, 10'd0, 12'd100, 12'd100, 12'd100, 12'd100);
        queue_target(16'h3456, 1'b1, 10'd5, 12'd100, 12'd100, 12'd101, 12'd100);
        queue_target(16'h4567, 1'b1, 10'd5, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
        queue_target(16'h5678, 1'b1, 10'd5, 12'd1, 12'd4094, 12'd1, 12'd4094);
        queue_frame_end(32'hffffffff);
        queue_target(16'h0000, 1'b1, 10'd9, 12'd0, 12'd0, 12'd0, 12'd0);
        queue_frame_end(32'd0);
        queue_frame_end(32'd1);
        queue_frame_end(32'd2);
        wait_drained();

        // axis-aligned box, no idling, then a long receiver hold
        reg_write(REG_VCOUNT, 64'd4);
        reg_write(REG_VERT_A, vertex_pair(16'd200, 16'd200, 16'd3800, 16'd200));
        reg_write(REG_VERT_B, vertex_pair(16'd3800, 16'd3800, 16'd200, 16'd3800));
        reg_write(REG_HIST, 64'd20);
        reg_write(REG_MOVE, 64'd8);
        reg_write(REG_THRESH, 64'd3);
        reg_write(REG_RECORD, 64'd1);
        region_lo = 150;
        region_hi = 3850;
        quiet = 1'b1;
        id_pool.delete();
        for (int i = 0; i < 12; i++)
            id_pool = {id_pool, 16'($urandom())};
        for (int f = 0; f < 6; f++)
            queue_random_frame();
        @(posedge clk);
        hold_req = 1'b1;
        run_phase(6, 30);
        quiet = 1'b0;

        // clipped vertex count, widest movement, longest history
        reg_write(REG_VCOUNT, 64'd7);
        reg_write(REG_VERT_A, vertex_pair(16'd2000, 16'd100, 16'd3900, 16'd1200));
        reg_write(REG_VERT_B, vertex_pair(16'd3900, 16'd3000, 16'd2000, 16'd4000));
        reg_write(REG_VERT_C, vertex_pair(16'd100, 16'd3000, 16'd100, 16'd1200));
        reg_write(REG_HIST, 64'd1023);
        reg_write(REG_MOVE, 64'd4095);
        reg_write(REG_THRESH, 64'd2);
        reg_write(REG_RECORD, 64'd2);
        region_lo = 0;
        region_hi = 4095;
        run_phase(5, 50);

        // empty polygon
        reg_write(REG_VCOUNT, 64'd0);
        reg_write(REG_HIST, 64'd1);
        reg_write(REG_THRESH, 64'd1);
        run_phase(5, 25);

        // triangle, no movement, top threshold
        reg_write(REG_VCOUNT, 64'd3);
        reg_write(REG_VERT_A, vertex_pair(16'd100, 16'd100, 16'd4000, 16'd2000));
        reg_write(REG_VERT_B, vertex_pair(16'd100, 16'd4000, 16'd0, 16'd0));
        reg_write(REG_MOVE, 64'd0);
        reg_write(REG_THRESH, 64'd65535);
        reg_write(REG_RECORD, 64'd0);
        region_lo = 100;
        region_hi = 3000;
        run_phase(4, 30);

        // random vertex words with one, two and six vertices in use
        reg_write(REG_VERT_A, {$urandom(), $urandom()});
        reg_write(REG_VERT_B, {$urandom(), $urandom()});
        reg_write(REG_VERT_C, {$urandom(), $urandom()});
        reg_write(REG_VCOUNT, 64'd1);
        reg_write(REG_MOVE, 64'd100);
        reg_write(REG_THRESH, 64'd1);
        run_phase(4, 15);
        reg_write(REG_VCOUNT, 64'd2);
        run_phase(4, 15);
        reg_write(REG_VCOUNT, 64'd6);
        run_phase(4, 30);

        // box again with a pool larger than the table
        reg_write(REG_VCOUNT, 64'd4);
        reg_write(REG_VERT_A, vertex_pair(16'd200, 16'd200, 16'd3800, 16'd200));
        reg_write(REG_VERT_B, vertex_pair(16'd3800, 16'd3800, 16'd200, 16'd3800));
        reg_write(REG_HIST, 64'd1);
        reg_write(REG_MOVE, 64'd20);
        reg_write(REG_THRESH, 64'd2);
        reg_write(REG_RECORD, 64'd3);
        region_lo = 300;
        region_hi = 3700;
        id_pool.delete();
        for (int i = 0; i < 40; i++)
            id_pool = {id_pool, 16'(16'h100 + i)};
        for (int i = 0; i < 40; i++)
            queue_target(id_pool[i], 1'b1, 10'd500, 12'd1000, 12'd1000, 12'd1000, 12'd1000);
        queue_frame_end($urandom());
        run_phase(10, 60);

        $display("covered %0d input transfers over several polygon settings: %0d frames,",
                 n_items, n_frames);
        $display("%0d stop and %0d unstop events, %0d table overflows",
                 n_stops, n_unstops, n_overflows);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

FILE: polygon_stop_dwell_detector.f
design/psdd_pkg.sv
design/psdd_ram.sv
design/psdd_poly.sv
design/polygon_stop_dwell_detector.sv
verif/testbench.sv
